// ===== rtl/core/tas_pkg.sv =====
// Shared types and constants for the throttle arming sequencer.
// No dependencies; every other file of the block uses this package.
package tas_pkg;

    typedef logic [9:0]  t_throttle;
    typedef logic [7:0]  t_count8;
    typedef logic [13:0] t_count14;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 14;

    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;
    typedef logic [CFG_DATA_W-1:0]  t_cfg_data;

    // Register indexes of the configuration port.
    localparam t_cfg_index CFG_HIGH_THRESHOLD = 3'd0;
    localparam t_cfg_index CFG_LOW_THRESHOLD  = 3'd1;
    localparam t_cfg_index CFG_HOLD_TICKS     = 3'd2;
    localparam t_cfg_index CFG_DISARM_TICKS   = 3'd3;
    localparam t_cfg_index CFG_LOSS_TICKS     = 3'd4;

    // Register reset values.
    localparam t_throttle RST_HIGH_THRESHOLD = 10'd960;
    localparam t_throttle RST_LOW_THRESHOLD  = 10'd20;
    localparam t_count8   RST_HOLD_TICKS     = 8'd200;
    localparam t_count14  RST_DISARM_TICKS   = 14'd10000;
    localparam t_count8   RST_LOSS_TICKS     = 8'd200;

    localparam t_count8  COUNT8_MAX  = 8'hFF;
    localparam t_count14 COUNT14_MAX = 14'h3FFF;

    typedef enum logic [2:0] {
        PH_FREE     = 3'd0,
        PH_HIGH     = 3'd1,
        PH_RELEASED = 3'd2,
        PH_LOW      = 3'd3,
        PH_UNLOCKED = 3'd4
    } t_phase;

    typedef struct packed {
        t_throttle high_threshold;
        t_throttle low_threshold;
        t_count8   hold_ticks;
        t_count14  disarm_ticks;
        t_count8   loss_ticks;
    } t_cfg;

    typedef struct packed {
        t_count8  miss_count;
        t_phase   phase;
        t_count8  high_count;
        t_count8  low_count;
        t_count14 disarm_count;
    } t_state;

    typedef struct packed {
        logic       link_up;
        logic       unlocked;
        logic [2:0] arm_phase;
    } t_result;

endpackage

// ===== rtl/core/tas_if.sv =====
// Handshake channels of the throttle arming sequencer: tick input,
// result output and configuration write. Depends on tas_pkg.
interface tas_tick_if;
    logic                valid;
    logic                ready;
    logic                packet_ok;
    tas_pkg::t_throttle  throttle;

    modport source (output valid, output packet_ok, output throttle, input ready);
    modport sink   (input valid, input packet_ok, input throttle, output ready);
endinterface

interface tas_result_if;
    logic       valid;
    logic       ready;
    logic       link_up;
    logic       unlocked;
    logic [2:0] arm_phase;

    modport source (output valid, output link_up, output unlocked, output arm_phase,
                    input ready);
    modport sink   (input valid, input link_up, input unlocked, input arm_phase,
                    output ready);
endinterface

interface tas_cfg_if;
    logic                valid;
    logic                ready;
    tas_pkg::t_cfg_index reg_index;
    tas_pkg::t_cfg_data  wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== rtl/core/tas_step.sv =====
// Next-state and result logic for one control tick: link watchdog and
// arming phase sequence. Purely combinational; depends on tas_pkg.
module tas_step (
    input  tas_pkg::t_cfg     i_cfg,
    input  tas_pkg::t_state   i_state,
    input  logic              i_packet_ok,
    input  tas_pkg::t_throttle i_throttle,
    output tas_pkg::t_state   o_state,
    output tas_pkg::t_result  o_result
);
    import tas_pkg::*;

    logic        hi;
    logic        lo;
    logic        link;
    logic        unl;
    logic [8:0]  miss_nx;
    logic [8:0]  high_nx;
    logic [8:0]  low_nx;
    logic [14:0] disarm_nx;

    always_comb begin
        hi        = (i_throttle >= i_cfg.high_threshold);
        lo        = (i_throttle <= i_cfg.low_threshold);
        miss_nx   = {1'b0, i_state.miss_count} + 9'd1;
        high_nx   = {1'b0, i_state.high_count} + 9'd1;
        low_nx    = {1'b0, i_state.low_count} + 9'd1;
        disarm_nx = {1'b0, i_state.disarm_count} + 15'd1;
        o_state   = i_state;
        unl       = 1'b0;

        // Watchdog: a packet clears the miss count, otherwise it climbs and
        // is clamped at the limit once the link is declared down.
        if (i_packet_ok) begin
            o_state.miss_count = '0;
            link = 1'b1;
        end else if (miss_nx > {1'b0, i_cfg.loss_ticks}) begin
            o_state.miss_count = i_cfg.loss_ticks;
            link = 1'b0;
        end else begin
            o_state.miss_count = miss_nx[7:0];
            link = 1'b1;
        end

        if (!link) begin
            o_state.phase = PH_FREE;
        end else begin
            case (i_state.phase)
                PH_FREE: begin
                    o_state.high_count = '0;
                    o_state.low_count  = '0;
                    if (hi) o_state.phase = PH_HIGH;
                end
                PH_HIGH: begin
                    if (hi) begin
                        o_state.high_count = high_nx[8] ? COUNT8_MAX : high_nx[7:0];
                        if (high_nx > {1'b0, i_cfg.hold_ticks}) o_state.phase = PH_RELEASED;
                    end else begin
                        o_state.phase = PH_FREE;
                    end
                end
                PH_RELEASED: begin
                    if (lo) o_state.phase = PH_LOW;
                end
                PH_LOW: begin
                    if (lo) begin
                        o_state.low_count = low_nx[8] ? COUNT8_MAX : low_nx[7:0];
                        if (low_nx > {1'b0, i_cfg.hold_ticks}) o_state.phase = PH_UNLOCKED;
                    end else begin
                        o_state.phase = PH_FREE;
                    end
                end
                PH_UNLOCKED: begin
                    unl = 1'b1;
                    if (lo) begin
                        if (disarm_nx > {1'b0, i_cfg.disarm_ticks}) begin
                            o_state.disarm_count = '0;
                            o_state.phase        = PH_FREE;
                        end else begin
                            o_state.disarm_count = disarm_nx[14] ? COUNT14_MAX
                                                                 : disarm_nx[13:0];
                        end
                    end else begin
                        o_state.disarm_count = '0;
                    end
                end
                default: begin
                end
            endcase
        end

        o_result.link_up   = link;
        o_result.unlocked  = unl;
        o_result.arm_phase = o_state.phase;
    end

endmodule

// ===== rtl/core/throttle_arming_sequencer.sv =====
// Throttle arming sequencer: a transferred tick waits in the input register and is stepped
// into the output register once that is empty or being read. Throughput is one tick per
// clock while the result receiver is ready; the input register, the single-pass step logic
// and the output register form a two-stage pipeline that never bubbles.
// Synchronous active-low reset loads the register defaults, sets the miss count
// to its saturated value (link down until the first packet) and the phase to free.
// Depends on tas_pkg, tas_if and tas_step.
module throttle_arming_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tas_tick_if.sink    i_tick,
    tas_cfg_if.sink     i_cfg,
    tas_result_if.source o_result
);
    import tas_pkg::*;

    // Configuration registers. Writes must only be issued while the block is idle; the
    // block does not enforce this, and the port is always ready.
    t_cfg r_cfg;

    // Input stage.
    logic      r_s1_valid;
    logic      r_s1_packet_ok;
    t_throttle r_s1_throttle;

    // Sequencer state, updated when the input stage moves into the output register.
    t_state r_state;
    t_state n_state;

    // Output register.
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;

    logic s1_adv;

    assign i_cfg.ready = 1'b1;

    // The input stage advances whenever the output register is empty or its
    // current result is being transferred out this cycle.
    assign s1_adv       = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_tick.ready = !r_s1_valid || s1_adv;

    tas_step u_step (
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .i_packet_ok (r_s1_packet_ok),
        .i_throttle  (r_s1_throttle),
        .o_state     (n_state),
        .o_result    (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_threshold <= RST_HIGH_THRESHOLD;
            r_cfg.low_threshold  <= RST_LOW_THRESHOLD;
            r_cfg.hold_ticks     <= RST_HOLD_TICKS;
            r_cfg.disarm_ticks   <= RST_DISARM_TICKS;
            r_cfg.loss_ticks     <= RST_LOSS_TICKS;
        end else if (i_cfg.valid) begin
            // Indexes beyond the register list are accepted and ignored.
            case (i_cfg.reg_index)
                CFG_HIGH_THRESHOLD: r_cfg.high_threshold <= i_cfg.wr_data[9:0];
                CFG_LOW_THRESHOLD:  r_cfg.low_threshold  <= i_cfg.wr_data[9:0];
                CFG_HOLD_TICKS:     r_cfg.hold_ticks     <= i_cfg.wr_data[7:0];
                CFG_DISARM_TICKS:   r_cfg.disarm_ticks   <= i_cfg.wr_data[13:0];
                CFG_LOSS_TICKS:     r_cfg.loss_ticks     <= i_cfg.wr_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_tick.valid && i_tick.ready) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick.valid && i_tick.ready) begin
            r_s1_packet_ok <= i_tick.packet_ok;
            r_s1_throttle  <= i_tick.throttle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.miss_count   <= RST_LOSS_TICKS;
            r_state.phase        <= PH_FREE;
            r_state.high_count   <= '0;
            r_state.low_count    <= '0;
            r_state.disarm_count <= '0;
        end else if (s1_adv) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.link_up   = r_out.link_up;
    assign o_result.unlocked  = r_out.unlocked;
    assign o_result.arm_phase = r_out.arm_phase;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the throttle arming sequencer: directed ticks, then random
// arming sequences under several register settings, each result checked against a predictor.
// Depends on tas_pkg, the channel interfaces in tas_if and the throttle_arming_sequencer RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tas_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int IDLE_PCT       = 34;
    localparam int PACKET_PCT     = 92;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 4;
    localparam int PRINT_LIMIT    = 50;
    localparam int THROTTLE_MAX   = 1023;
    localparam int PHASE_TICKS    = 70;

    // One tick as the sender sees it: packet flag and throttle.
    typedef struct packed {
        logic      packet_ok;
        t_throttle throttle;
    } t_tick_item;

    // Throttle bands relative to the current thresholds.
    typedef enum logic [1:0] {
        BAND_HIGH,
        BAND_LOW,
        BAND_MID,
        BAND_ANY
    } t_thr_band;

    logic i_clk;
    logic i_rst_n;

    tas_tick_if   tick_bus();
    tas_cfg_if    cfg_bus();
    tas_result_if result_bus();

    throttle_arming_sequencer dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick_bus),
        .i_cfg    (cfg_bus),
        .o_result (result_bus)
    );

    // Shadow copy of the configuration registers, updated on each register transfer.
    t_throttle cfg_high;
    t_throttle cfg_low;
    t_count8   cfg_hold;
    t_count14  cfg_disarm;
    t_count8   cfg_loss;

    // Predicted sequencer state.
    t_count8  miss_cnt;
    t_phase   arm_ph;
    t_count8  high_cnt;
    t_count8  low_cnt;
    t_count14 disarm_cnt;

    t_tick_item tick_queue[$];
    t_result    exp_results[$];

    int  mismatch_cnt;
    int  results_checked;
    int  ticks_queued;
    int  ticks_accepted;
    int  reg_writes;
    int  settings_loaded;
    int  holdoff_left;
    bit  holdoff_done;
    bit  no_idle;

    always #(CLK_HALF) i_clk = ~i_clk;

    // Prints one line per mismatch (up to a limit) and counts every one of them.
    task automatic report_mismatch(input string msg);
        if (mismatch_cnt < PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatch_cnt++;
    endtask

    // Advances the predicted state by one tick and returns the result it must produce.
    // The watchdog runs first; a dead link forces the free phase but leaves the hold
    // and disarm counts alone. Counts compare at full precision and saturate on store.
    function automatic t_result arm_step(input logic pkt, input t_throttle thr);
        t_result res;
        logic    link;
        logic    unl;
        logic    hi;
        logic    lo;
        int      nxt;
        hi  = (thr >= cfg_high);
        lo  = (thr <= cfg_low);
        unl = 1'b0;
        if (pkt) begin
            miss_cnt = '0;
            link     = 1'b1;
        end else begin
            nxt = int'(miss_cnt) + 1;
            if (nxt > int'(cfg_loss)) begin
                miss_cnt = cfg_loss;
                link     = 1'b0;
            end else begin
                miss_cnt = t_count8'(nxt);
                link     = 1'b1;
            end
        end
        if (!link) begin
            arm_ph = PH_FREE;
        end else begin
            case (arm_ph)
                PH_FREE: begin
                    // The tick that clears the hold counts may already move on.
                    high_cnt = '0;
                    low_cnt  = '0;
                    if (hi) arm_ph = PH_HIGH;
                end
                PH_HIGH: begin
                    if (hi) begin
                        nxt      = int'(high_cnt) + 1;
                        high_cnt = (nxt > int'(COUNT8_MAX)) ? COUNT8_MAX : t_count8'(nxt);
                        if (nxt > int'(cfg_hold)) arm_ph = PH_RELEASED;
                    end else begin
                        arm_ph = PH_FREE;
                    end
                end
                PH_RELEASED: begin
                    if (lo) arm_ph = PH_LOW;
                end
                PH_LOW: begin
                    if (lo) begin
                        nxt     = int'(low_cnt) + 1;
                        low_cnt = (nxt > int'(COUNT8_MAX)) ? COUNT8_MAX : t_count8'(nxt);
                        if (nxt > int'(cfg_hold)) arm_ph = PH_UNLOCKED;
                    end else begin
                        arm_ph = PH_FREE;
                    end
                end
                PH_UNLOCKED: begin
                    // Unlocked is reported on the disarming tick as well.
                    unl = 1'b1;
                    if (lo) begin
                        nxt = int'(disarm_cnt) + 1;
                        if (nxt > int'(cfg_disarm)) begin
                            disarm_cnt = '0;
                            arm_ph     = PH_FREE;
                        end else begin
                            disarm_cnt = (nxt > int'(COUNT14_MAX)) ? COUNT14_MAX
                                                                   : t_count14'(nxt);
                        end
                    end else begin
                        disarm_cnt = '0;
                    end
                end
                default: begin
                end
            endcase
        end
        res.link_up   = link;
        res.unlocked  = unl;
        res.arm_phase = arm_ph;
        return res;
    endfunction

    function automatic t_throttle pick_throttle(input t_thr_band band);
        case (band)
            BAND_HIGH: return t_throttle'($urandom_range(THROTTLE_MAX, cfg_high));
            BAND_LOW:  return t_throttle'($urandom_range(cfg_low, 0));
            BAND_MID: begin
                if (int'(cfg_high) > int'(cfg_low) + 1) begin
                    return t_throttle'($urandom_range(int'(cfg_high) - 1, int'(cfg_low) + 1));
                end
                return t_throttle'($urandom_range(THROTTLE_MAX, 0));
            end
            default: return t_throttle'($urandom_range(THROTTLE_MAX, 0));
        endcase
    endfunction

    function automatic logic rand_packet();
        return ($urandom_range(99) < PACKET_PCT);
    endfunction

    task automatic push_tick(input logic pkt, input t_throttle thr);
        t_tick_item item;
        item.packet_ok = pkt;
        item.throttle  = thr;
        tick_queue.push_back(item);
        ticks_queued++;
    endtask

    // One register transfer on the configuration channel. The shadow register changes
    // at the same edge as the block's register.
    task automatic write_reg(input t_cfg_index idx, input int unsigned value);
        @(posedge i_clk);
        cfg_bus.valid     <= 1'b1;
        cfg_bus.reg_index <= idx;
        cfg_bus.wr_data   <= t_cfg_data'(value);
        do @(posedge i_clk); while (!(cfg_bus.valid && cfg_bus.ready));
        cfg_bus.valid <= 1'b0;
        case (idx)
            CFG_HIGH_THRESHOLD: cfg_high   = t_throttle'(value);
            CFG_LOW_THRESHOLD:  cfg_low    = t_throttle'(value);
            CFG_HOLD_TICKS:     cfg_hold   = t_count8'(value);
            CFG_DISARM_TICKS:   cfg_disarm = t_count14'(value);
            CFG_LOSS_TICKS:     cfg_loss   = t_count8'(value);
            default: begin
            end
        endcase
        reg_writes++;
    endtask

    task automatic load_setting(input int unsigned hi, input int unsigned lo,
                                input int unsigned hold, input int unsigned disarm,
                                input int unsigned loss);
        write_reg(CFG_HIGH_THRESHOLD, hi);
        write_reg(CFG_LOW_THRESHOLD, lo);
        write_reg(CFG_HOLD_TICKS, hold);
        write_reg(CFG_DISARM_TICKS, disarm);
        write_reg(CFG_LOSS_TICKS, loss);
        settings_loaded++;
    endtask

    // Waits until every queued tick has been transferred and every result has come back,
    // then lets the pipeline run empty.
    task automatic wait_drained();
        while (tick_queue.size() != 0 || tick_bus.valid || exp_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Random part of one setting. Most of it is complete arming sequences with random
    // run lengths around the hold and disarm counts, so that some sequences fall one
    // tick short and others arm and disarm; the rest is noise and bursts of missed
    // packets long enough to drop the link.
    task automatic run_random_phase(input int count);
        int start;
        int len;
        int k;
        start = ticks_queued;
        while (ticks_queued - start < count) begin
            if ($urandom_range(99) < 70) begin
                len = int'(cfg_hold) + $urandom_range(4, 0);
                for (k = 0; k < len; k++) push_tick(rand_packet(), pick_throttle(BAND_HIGH));
                len = $urandom_range(3, 0);
                for (k = 0; k < len; k++) push_tick(rand_packet(), pick_throttle(BAND_MID));
                len = int'(cfg_hold) + $urandom_range(4, 0);
                for (k = 0; k < len; k++) push_tick(rand_packet(), pick_throttle(BAND_LOW));
                len = int'(cfg_disarm) + $urandom_range(4, 0);
                for (k = 0; k < len; k++) begin
                    push_tick(rand_packet(), pick_throttle(($urandom_range(9) == 0) ?
                                                           BAND_MID : BAND_LOW));
                end
            end else if ($urandom_range(99) < 40) begin
                len = int'(cfg_loss) + $urandom_range(3, 1);
                for (k = 0; k < len; k++) push_tick(1'b0, pick_throttle(BAND_ANY));
            end else begin
                len = $urandom_range(8, 1);
                for (k = 0; k < len; k++) begin
                    push_tick(1'($urandom_range(1)), pick_throttle(BAND_ANY));
                end
            end
        end
    endtask

    // Tick driver. A tick is predicted at the edge where its transfer happens. The next
    // tick is only put on the channel once the current one is gone, so valid gets one
    // nonblocking write per edge at most.
    always @(posedge i_clk) begin
        t_tick_item item;
        logic       skip;
        if (i_rst_n) begin
            if (tick_bus.valid && tick_bus.ready) begin
                exp_results.push_back(arm_step(tick_bus.packet_ok, tick_bus.throttle));
                ticks_accepted++;
            end
            if (!tick_bus.valid || tick_bus.ready) begin
                skip = !no_idle && ($urandom_range(99) < IDLE_PCT);
                if (tick_queue.size() != 0 && !skip) begin
                    item = tick_queue.pop_front();
                    tick_bus.valid     <= 1'b1;
                    tick_bus.packet_ok <= item.packet_ok;
                    tick_bus.throttle  <= item.throttle;
                end else begin
                    // Junk payload while idle, so a tick taken without valid shows up.
                    tick_bus.valid     <= 1'b0;
                    tick_bus.packet_ok <= 1'($urandom_range(1));
                    tick_bus.throttle  <= t_throttle'($urandom_range(THROTTLE_MAX, 0));
                end
            end
        end
    end

    // Hold-off counter. Once, while plenty of ticks are still queued, the receiver
    // holds off for a long stretch so that the block fills up and stalls its tick input.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (holdoff_left > 0) begin
                holdoff_left <= holdoff_left - 1;
            end else if (!holdoff_done && results_checked >= 100 && tick_queue.size() >= 40) begin
                holdoff_done <= 1'b1;
                holdoff_left <= HOLDOFF_CYCLES;
            end
        end
    end

    // Result monitor. Every result transfer is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (result_bus.valid && result_bus.ready) begin
                if (exp_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no tick pending",
                                              results_checked));
                end else begin
                    want = exp_results.pop_front();
                    if (result_bus.link_up !== want.link_up) begin
                        report_mismatch($sformatf("result %0d link_up got %b expected %b",
                                        results_checked, result_bus.link_up, want.link_up));
                    end
                    if (result_bus.unlocked !== want.unlocked) begin
                        report_mismatch($sformatf("result %0d unlocked got %b expected %b",
                                        results_checked, result_bus.unlocked, want.unlocked));
                    end
                    if (result_bus.arm_phase !== want.arm_phase) begin
                        report_mismatch($sformatf("result %0d arm_phase got %0d expected %0d",
                                        results_checked, result_bus.arm_phase,
                                        want.arm_phase));
                    end
                end
                results_checked++;
            end
            if (holdoff_left > 0) begin
                result_bus.ready <= 1'b0;
            end else begin
                result_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int k;
        i_clk   = 1'b0;
        i_rst_n = 1'b0;
        tick_bus.valid     = 1'b0;
        tick_bus.packet_ok = 1'b0;
        tick_bus.throttle  = '0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.reg_index  = '0;
        cfg_bus.wr_data    = '0;
        result_bus.ready   = 1'b0;

        // Shadow registers and state as the block leaves reset: the watchdog starts
        // saturated, so the link is down until the first packet.
        cfg_high   = RST_HIGH_THRESHOLD;
        cfg_low    = RST_LOW_THRESHOLD;
        cfg_hold   = RST_HOLD_TICKS;
        cfg_disarm = RST_DISARM_TICKS;
        cfg_loss   = RST_LOSS_TICKS;
        miss_cnt   = RST_LOSS_TICKS;
        arm_ph     = PH_FREE;
        high_cnt   = '0;
        low_cnt    = '0;
        disarm_cnt = '0;

        mismatch_cnt    = 0;
        results_checked = 0;
        ticks_queued    = 0;
        ticks_accepted  = 0;
        reg_writes      = 0;
        settings_loaded = 0;
        holdoff_left    = 0;
        holdoff_done    = 1'b0;
        no_idle         = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: link down from the start, first packet brings it up, the
        // high threshold boundary, and a missed tick that keeps the link.
        push_tick(1'b0, 10'd0);
        push_tick(1'b1, 10'd1023);
        push_tick(1'b1, 10'd960);
        push_tick(1'b1, 10'd959);
        push_tick(1'b0, 10'd1023);
        push_tick(1'b1, 10'd20);
        wait_drained();

        // Short holds: arming at the threshold boundaries, link loss in the low hold
        // that keeps the counts, a full arm, a disarm count broken by a raised stick,
        // and the disarming tick that still reports unlocked.
        load_setting(512, 100, 1, 2, 1);
        push_tick(1'b1, 10'd600);
        push_tick(1'b1, 10'd600);
        push_tick(1'b1, 10'd1023);
        push_tick(1'b1, 10'd300);
        push_tick(1'b1, 10'd100);
        push_tick(1'b0, 10'd50);
        push_tick(1'b0, 10'd0);
        push_tick(1'b1, 10'd512);
        push_tick(1'b1, 10'd512);
        push_tick(1'b1, 10'd700);
        for (k = 0; k < 4; k++) push_tick(1'b1, 10'd0);
        push_tick(1'b1, 10'd500);
        for (k = 0; k < 4; k++) push_tick(1'b1, 10'd0);
        wait_drained();

        // Random part under several settings, thresholds and counts at their extremes.
        run_random_phase(PHASE_TICKS);
        wait_drained();
        load_setting(1023, 0, 0, 0, 0);
        run_random_phase(PHASE_TICKS);
        wait_drained();
        load_setting(0, 1023, 4, 6, 5);
        run_random_phase(PHASE_TICKS);
        wait_drained();
        // This setting runs with both sides always ready.
        load_setting($urandom_range(THROTTLE_MAX, 0), $urandom_range(THROTTLE_MAX, 0),
                     $urandom_range(6, 0), $urandom_range(12, 0), $urandom_range(8, 0));
        no_idle = 1'b1;
        run_random_phase(PHASE_TICKS);
        wait_drained();
        no_idle = 1'b0;
        load_setting($urandom_range(THROTTLE_MAX, 0), $urandom_range(THROTTLE_MAX, 0),
                     $urandom_range(6, 0), $urandom_range(12, 0), $urandom_range(8, 0));
        run_random_phase(PHASE_TICKS);
        wait_drained();

        // Largest hold and loss counts: the holds fill the hold count to its top value
        // and the watchdog must still fire. A short disarm count lets the unlocked phase
        // fall back to free. Packet gaps stay far below the loss count until the burst.
        load_setting(1023, 0, 254, 24, 254);
        for (k = 0; k < 258; k++) push_tick(rand_packet(), 10'd1023);
        for (k = 0; k < 258; k++) push_tick(rand_packet(), 10'd0);
        for (k = 0; k < 30; k++) push_tick(rand_packet(), 10'd0);
        for (k = 0; k < 260; k++) push_tick(1'b0, pick_throttle(BAND_ANY));
        wait_drained();

        $display("Run covered %0d ticks and %0d results over %0d register settings (%0d writes).",
                 ticks_accepted, results_checked, settings_loaded, reg_writes);
        $display("Arming, disarm, link loss and maximum counts exercised; %0d mismatches.",
                 mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog on the whole run, far beyond the slowest correct run.
    initial begin
        #(2_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule
